// ===== sv/tlpt_pkg.sv =====
// Package with types, constants and codes of the two-level page table engine.
`timescale 1ns / 1ps
package tlpt_pkg;

  localparam int DIR_ENTRIES   = 768;
  localparam int TABLE_ENTRIES = 1024;
  localparam int TABLE_POOL    = 16;

  localparam int DIR_W   = (DIR_ENTRIES > 1) ? $clog2(DIR_ENTRIES) : 1;
  localparam int TSLOT_W = $clog2(TABLE_ENTRIES);
  localparam int POOL_W  = (TABLE_POOL > 1) ? $clog2(TABLE_POOL) : 1;
  localparam int CNT_W   = $clog2(TABLE_POOL + 1);
  localparam int STORE_W = POOL_W + TSLOT_W;
  localparam int ENTRY_W = 22;
  localparam int PAGE_W  = 20;
  localparam int FRAME_W = 20;
  localparam int WORD_W  = 32;
  localparam int DADDR_W = PAGE_W - TSLOT_W;

  typedef enum logic [2:0] {
    CMD_SET     = 3'd0,
    CMD_GET     = 3'd1,
    CMD_CLEAR   = 3'd2,
    CMD_FIRST   = 3'd3,
    CMD_NEXT    = 3'd4,
    CMD_DESTROY = 3'd5
  } cmd_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIR_RD,
    ST_DIR_CHK,
    ST_ZERO,
    ST_WRITE,
    ST_ENT_RD,
    ST_ENT_CHK,
    ST_SCAN_DIR,
    ST_SCAN_DCHK,
    ST_SCAN_ENT,
    ST_SCAN_ECHK,
    ST_WIPE,
    ST_OUT,
    ST_INIT
  } state_e;

  // Controller to datapath commands.
  typedef struct packed {
    logic load;        // capture the input beat
    logic dir_rd;      // read directory at current slot
    logic alloc;       // write directory entry with new pool index
    logic zero_wr;     // write zero at zero counter, advance
    logic ent_wr;      // write the set entry
    logic ent_clr;     // clear the addressed entry
    logic ent_rd;      // read store at current entry
    logic scan_start;  // start scan from captured page (+1 for next)
    logic scan_first;  // start scan from zero
    logic scan_nslot;  // advance scan to next directory slot
    logic scan_nent;   // advance scan to next entry
    logic wipe_wr;     // clear directory at wipe counter, advance
    logic wipe_start;
    logic res_clr;     // clear result
    logic res_set;     // result for set
    logic res_get;     // result from read entry (get)
    logic res_scan;    // result from read entry (scan)
    logic out_valid;
  } ctl_t;

  // Datapath to controller status.
  typedef struct packed {
    cmd_e cmd;
    logic in_range;
    logic dir_valid;
    logic pool_full;
    logic zero_last;
    logic ent_nz;
    logic scan_dir_end;   // scan slot beyond directory
    logic scan_ent_last;  // scan entry at last slot of table
    logic wipe_last;
    logic out_taken;
  } sts_t;

  function automatic logic [WORD_W-1:0] word_of(input logic [ENTRY_W-1:0] e);
    word_of = {e[ENTRY_W-1:2], 9'd0, e[0], e[1], e[0]};
  endfunction

endpackage

// ===== sv/tlpt_if.sv =====
// Valid/ready channel interfaces for input and result beats.
`timescale 1ns / 1ps
interface tlpt_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  command;
  logic [19:0] page_number;
  logic [19:0] frame_number;
  logic        writable;
  modport source (output valid, command, page_number, frame_number, writable, input ready);
  modport sink (input valid, command, page_number, frame_number, writable, output ready);
endinterface

interface tlpt_out_if;
  logic        valid;
  logic        ready;
  logic        ok;
  logic [19:0] found_page;
  logic [19:0] found_frame;
  logic [31:0] entry_word;
  modport source (output valid, ok, found_page, found_frame, entry_word, input ready);
  modport sink (input valid, ok, found_page, found_frame, entry_word, output ready);
endinterface

// ===== sv/two_level_page_table_engine.sv =====
// Top level of the two-level page table engine.
// The engine takes one command beat on in_ch (set, get, clear, first, next,
// destroy) and returns exactly one result beat on out_ch.
// Each beat is handled alone: in_ch.ready is high only while the engine is idle.
// A set that takes a new table first zeroes it one entry a cycle through the
// single store port. Destroy clears the directory one slot a cycle. First and
// next read one directory slot or one table entry at a time, each read then
// checked, until a mapped page is found or the directory ends.
// After reset the engine clears the directory one slot a cycle, and in_ch.ready
// stays low until every slot has been cleared.
// A result waits in the output register while out_ch.ready is low; no new
// command is taken until it has been delivered.
`timescale 1ns / 1ps
module two_level_page_table_engine
  import tlpt_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  tlpt_in_if.sink     in_ch,
  tlpt_out_if.source  out_ch
);

  ctl_t ctl;
  sts_t sts;

  tlpt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_ch.valid),
    .in_ready_o (in_ch.ready),
    .sts_i      (sts),
    .ctl_o      (ctl)
  );

  tlpt_datapath u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .command_i      (in_ch.command),
    .page_number_i  (in_ch.page_number),
    .frame_number_i (in_ch.frame_number),
    .writable_i     (in_ch.writable),
    .out_ready_i    (out_ch.ready),
    .ctl_i          (ctl),
    .sts_o          (sts),
    .ok_o           (out_ch.ok),
    .found_page_o   (out_ch.found_page),
    .found_frame_o  (out_ch.found_frame),
    .entry_word_o   (out_ch.entry_word)
  );

  assign out_ch.valid = ctl.out_valid;

endmodule

// ===== sv/tlpt_ctrl.sv =====
// Controller state machine of the page table engine.
`timescale 1ns / 1ps
module tlpt_ctrl
  import tlpt_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  sts_t sts_i,
  output ctl_t ctl_o
);

  state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands.
  always_comb begin
    state_d    = state_q;
    ctl_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_INIT: begin
        ctl_o.wipe_wr = 1'b1;
        if (sts_i.wipe_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          ctl_o.load = 1'b1;
          state_d    = ST_DIR_RD;
        end
      end
      ST_DIR_RD: begin
        ctl_o.res_clr = 1'b1;
        case (sts_i.cmd)
          CMD_SET, CMD_GET, CMD_CLEAR: begin
            ctl_o.dir_rd = 1'b1;
            state_d      = ST_DIR_CHK;
          end
          CMD_FIRST: begin
            ctl_o.scan_first = 1'b1;
            state_d          = ST_SCAN_DIR;
          end
          CMD_NEXT: begin
            ctl_o.scan_start = 1'b1;
            state_d          = ST_SCAN_DIR;
          end
          CMD_DESTROY: begin
            ctl_o.wipe_start = 1'b1;
            state_d          = ST_WIPE;
          end
          default: state_d = ST_OUT;
        endcase
      end
      ST_DIR_CHK: begin
        if (!sts_i.in_range) begin
          state_d = ST_OUT;
        end else if (sts_i.cmd == CMD_SET) begin
          if (sts_i.dir_valid) begin
            state_d = ST_WRITE;
          end else if (sts_i.pool_full) begin
            state_d = ST_OUT;
          end else begin
            ctl_o.alloc = 1'b1;
            state_d     = ST_ZERO;
          end
        end else if (!sts_i.dir_valid) begin
          state_d = ST_OUT;
        end else if (sts_i.cmd == CMD_CLEAR) begin
          ctl_o.ent_clr = 1'b1;
          state_d       = ST_OUT;
        end else begin
          ctl_o.ent_rd = 1'b1;
          state_d      = ST_ENT_CHK;
        end
      end
      ST_ZERO: begin
        ctl_o.zero_wr = 1'b1;
        if (sts_i.zero_last) state_d = ST_WRITE;
      end
      ST_WRITE: begin
        ctl_o.ent_wr  = 1'b1;
        ctl_o.res_set = 1'b1;
        state_d       = ST_OUT;
      end
      ST_ENT_CHK: begin
        ctl_o.res_get = 1'b1;
        state_d       = ST_OUT;
      end
      ST_SCAN_DIR: begin
        if (sts_i.scan_dir_end) begin
          state_d = ST_OUT;
        end else begin
          ctl_o.dir_rd = 1'b1;
          state_d      = ST_SCAN_DCHK;
        end
      end
      ST_SCAN_DCHK: begin
        if (sts_i.dir_valid) begin
          ctl_o.ent_rd = 1'b1;
          state_d      = ST_SCAN_ECHK;
        end else begin
          ctl_o.scan_nslot = 1'b1;
          state_d          = ST_SCAN_DIR;
        end
      end
      ST_SCAN_ENT: begin
        ctl_o.ent_rd = 1'b1;
        state_d      = ST_SCAN_ECHK;
      end
      ST_SCAN_ECHK: begin
        if (sts_i.ent_nz) begin
          ctl_o.res_scan = 1'b1;
          state_d        = ST_OUT;
        end else if (sts_i.scan_ent_last) begin
          ctl_o.scan_nslot = 1'b1;
          state_d          = ST_SCAN_DIR;
        end else begin
          ctl_o.scan_nent = 1'b1;
          state_d         = ST_SCAN_ENT;
        end
      end
      ST_WIPE: begin
        ctl_o.wipe_wr = 1'b1;
        if (sts_i.wipe_last) state_d = ST_OUT;
      end
      ST_OUT: begin
        ctl_o.out_valid = 1'b1;
        if (sts_i.out_taken) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ZERO && sts_i.zero_last) |=> state_q == ST_WRITE)
    else $error("zero pass did not end in entry write");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !ctl_o.out_valid)
    else $error("input taken while a result is pending");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_OUT && !sts_i.out_taken) |=> state_q == ST_OUT)
    else $error("result dropped under stall");

endmodule

// ===== sv/tlpt_datapath.sv =====
// Datapath: directory and pool memories, scan and sweep counters, result register.
`timescale 1ns / 1ps
module tlpt_datapath
  import tlpt_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [2:0]          command_i,
  input  logic [PAGE_W-1:0]   page_number_i,
  input  logic [FRAME_W-1:0]  frame_number_i,
  input  logic                writable_i,
  input  logic                out_ready_i,
  input  ctl_t                ctl_i,
  output sts_t                sts_o,
  output logic                ok_o,
  output logic [PAGE_W-1:0]   found_page_o,
  output logic [FRAME_W-1:0]  found_frame_o,
  output logic [WORD_W-1:0]   entry_word_o
);

  // Captured beat.
  logic [2:0]         cmd_q;
  logic [FRAME_W-1:0] frame_q;
  logic               wr_q;
  // Current position: directory slot and table slot.
  logic [DADDR_W-1:0] slot_q;
  logic [TSLOT_W-1:0] tslot_q;
  logic               dir_end_q;

  // Directory memory; each word holds the valid bit over the pool index.
  logic [POOL_W:0]        dir_mem [DIR_ENTRIES];
  logic [POOL_W:0]        dir_word_q;
  logic [POOL_W-1:0]      dir_idx;
  logic                   dir_hit;
  logic [ENTRY_W-1:0]     store_mem [TABLE_POOL * TABLE_ENTRIES];
  logic [ENTRY_W-1:0]     ent_q;
  logic [CNT_W-1:0]       used_q;
  logic [TSLOT_W-1:0]     zcnt_q;
  logic [DIR_W-1:0]       wcnt_q;

  logic in_range;
  logic [DIR_W-1:0] slot_idx;
  logic [PAGE_W:0]  next_page;

  assign in_range  = {{(32-DADDR_W){1'b0}}, slot_q} < DIR_ENTRIES;
  assign slot_idx  = slot_q[DIR_W-1:0];
  assign next_page = {1'b0, slot_q, tslot_q} + 1'b1;
  assign dir_idx   = dir_word_q[POOL_W-1:0];
  assign dir_hit   = in_range && dir_word_q[POOL_W];

  // Beat capture and scan position.
  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      cmd_q   <= command_i;
      frame_q <= frame_number_i;
      wr_q    <= writable_i;
      slot_q  <= page_number_i[PAGE_W-1:TSLOT_W];
      tslot_q <= page_number_i[TSLOT_W-1:0];
    end
    if (ctl_i.scan_first) begin
      slot_q    <= '0;
      tslot_q   <= '0;
      dir_end_q <= 1'b0;
    end else if (ctl_i.scan_start) begin
      slot_q    <= next_page[PAGE_W-1:TSLOT_W];
      tslot_q   <= next_page[TSLOT_W-1:0];
      dir_end_q <= next_page[PAGE_W] ||
                   ({{(32-DADDR_W){1'b0}}, next_page[PAGE_W-1:TSLOT_W]} >= DIR_ENTRIES);
    end else if (ctl_i.scan_nslot) begin
      slot_q    <= slot_q + 1'b1;
      tslot_q   <= '0;
      dir_end_q <= ({{(32-DADDR_W){1'b0}}, slot_q} + 32'd1 >= DIR_ENTRIES);
    end else if (ctl_i.scan_nent) begin
      tslot_q <= tslot_q + 1'b1;
    end
  end

  // Directory read, allocation write and sweep clear.
  always_ff @(posedge clk_i) begin
    if (ctl_i.dir_rd) begin
      dir_word_q <= dir_mem[slot_idx];
    end else if (ctl_i.alloc) begin
      dir_word_q <= {1'b1, used_q[POOL_W-1:0]};
    end
    if (ctl_i.alloc) begin
      dir_mem[slot_idx] <= {1'b1, used_q[POOL_W-1:0]};
    end else if (ctl_i.wipe_wr) begin
      dir_mem[wcnt_q] <= '0;
    end
  end

  // Pool count and the zero and sweep counters.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q    <= '0;
      wcnt_q    <= '0;
      zcnt_q    <= '0;
    end else begin
      if (ctl_i.alloc) begin
        used_q <= used_q + 1'b1;
        zcnt_q <= '0;
      end
      if (ctl_i.zero_wr) zcnt_q <= zcnt_q + 1'b1;
      if (ctl_i.wipe_start) wcnt_q <= '0;
      if (ctl_i.wipe_wr) begin
        wcnt_q <= wcnt_q + 1'b1;
        used_q <= '0;
      end
    end
  end

  // Pool store: one write or one read per cycle.
  always_ff @(posedge clk_i) begin
    if (ctl_i.zero_wr) begin
      store_mem[{dir_idx, zcnt_q}] <= '0;
    end else if (ctl_i.ent_wr) begin
      store_mem[{dir_idx, tslot_q}] <= {frame_q, wr_q, 1'b1};
    end else if (ctl_i.ent_clr) begin
      store_mem[{dir_idx, tslot_q}] <= '0;
    end
    if (ctl_i.ent_rd) ent_q <= store_mem[{dir_idx, tslot_q}];
  end

  // Result register.
  always_ff @(posedge clk_i) begin
    if (ctl_i.res_clr) begin
      ok_o          <= 1'b0;
      found_page_o  <= '0;
      found_frame_o <= '0;
      entry_word_o  <= '0;
    end else if (ctl_i.res_set) begin
      ok_o         <= 1'b1;
      entry_word_o <= word_of({frame_q, wr_q, 1'b1});
    end else if ((ctl_i.res_get || ctl_i.res_scan) && ent_q != '0) begin
      ok_o          <= 1'b1;
      found_frame_o <= ent_q[ENTRY_W-1:2];
      entry_word_o  <= word_of(ent_q);
      if (ctl_i.res_scan) found_page_o <= {slot_q, tslot_q};
    end
  end

  always_comb begin
    sts_o.cmd           = cmd_e'(cmd_q);
    sts_o.in_range      = in_range;
    sts_o.dir_valid     = dir_hit;
    sts_o.pool_full     = {{(32-CNT_W){1'b0}}, used_q} >= TABLE_POOL;
    sts_o.zero_last     = &zcnt_q;
    sts_o.ent_nz        = ent_q != '0;
    sts_o.scan_dir_end  = dir_end_q;
    sts_o.scan_ent_last = &tslot_q;
    sts_o.wipe_last     = {{(32-DIR_W){1'b0}}, wcnt_q} == DIR_ENTRIES - 1;
    sts_o.out_taken     = ctl_i.out_valid && out_ready_i;
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.alloc |-> {{(32-CNT_W){1'b0}}, used_q} < TABLE_POOL)
    else $error("table allocated from an exhausted pool");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.ent_wr |-> dir_hit)
    else $error("entry written without a table");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.wipe_wr && sts_o.wipe_last |=> used_q == '0)
    else $error("pool count not empty after directory sweep");

endmodule

// ===== tb/tb_two_level_page_table_engine.sv =====
// Testbench for the two-level page table engine: random and directed commands with a scoreboard.
`timescale 1ns / 1ps
module tb_two_level_page_table_engine;
  import tlpt_pkg::*;

  typedef struct packed {
    logic              ok;
    logic [PAGE_W-1:0]  page;
    logic [FRAME_W-1:0] frame;
    logic [WORD_W-1:0]  word;
  } lookup_t;

  // Shadow page table and the queue of lookups the engine still owes.
  class page_table_scoreboard;
    bit                 slot_valid [DIR_ENTRIES];
    int unsigned        slot_table [DIR_ENTRIES];
    logic [ENTRY_W-1:0] entries [TABLE_POOL*TABLE_ENTRIES];
    int unsigned        taken;
    lookup_t            owed [$];
    int unsigned        errors;
    logic [PAGE_W-1:0]  last_found;

    function new();
      foreach (slot_valid[i]) slot_valid[i] = 0;
      foreach (entries[i]) entries[i] = '0;
      taken = 0;
      errors = 0;
      last_found = '0;
    endfunction

    function automatic logic [WORD_W-1:0] pte_word(logic [ENTRY_W-1:0] e);
      return {e[ENTRY_W-1:2], 9'd0, e[0], e[1], e[0]};
    endfunction

    // Walk upward from a page to the next nonzero entry.
    function automatic lookup_t scan_up(int unsigned start);
      lookup_t     r;
      int unsigned d;
      int unsigned t;
      int unsigned base;
      r = '0;
      t = start % TABLE_ENTRIES;
      for (d = start / TABLE_ENTRIES; d < DIR_ENTRIES; d++) begin
        if (slot_valid[d]) begin
          base = slot_table[d] * TABLE_ENTRIES;
          for (; t < TABLE_ENTRIES; t++) begin
            if (entries[base + t] != '0) begin
              r.ok = 1'b1;
              r.page = PAGE_W'(d * TABLE_ENTRIES + t);
              r.frame = entries[base + t][ENTRY_W-1:2];
              r.word = pte_word(entries[base + t]);
              last_found = r.page;
              return r;
            end
          end
        end
        t = 0;
      end
      return r;
    endfunction

    // Apply one accepted command to the shadow state and queue its lookup.
    function void note_command(logic [2:0] cmd, logic [PAGE_W-1:0] page,
                               logic [FRAME_W-1:0] frame, logic wr);
      lookup_t            r;
      int unsigned        d;
      int unsigned        t;
      bit                 in_range;
      bit                 mapped;
      logic [ENTRY_W-1:0] e;
      r = '0;
      d = page / TABLE_ENTRIES;
      t = page % TABLE_ENTRIES;
      in_range = d < DIR_ENTRIES;
      mapped = in_range && slot_valid[d];
      case (cmd)
        CMD_SET: begin
          if (in_range && (mapped || taken < TABLE_POOL)) begin
            if (!mapped) begin
              slot_valid[d] = 1;
              slot_table[d] = taken;
              for (int i = 0; i < TABLE_ENTRIES; i++) entries[taken*TABLE_ENTRIES + i] = '0;
              taken++;
            end
            e = {frame, wr, 1'b1};
            entries[slot_table[d]*TABLE_ENTRIES + t] = e;
            r.ok = 1'b1;
            r.word = pte_word(e);
          end
        end
        CMD_GET: begin
          if (mapped && entries[slot_table[d]*TABLE_ENTRIES + t] != '0) begin
            e = entries[slot_table[d]*TABLE_ENTRIES + t];
            r.ok = 1'b1;
            r.frame = e[ENTRY_W-1:2];
            r.word = pte_word(e);
          end
        end
        CMD_CLEAR: if (mapped) entries[slot_table[d]*TABLE_ENTRIES + t] = '0;
        CMD_FIRST: r = scan_up(0);
        CMD_NEXT: r = scan_up(int'(page) + 1);
        CMD_DESTROY: begin
          foreach (slot_valid[i]) slot_valid[i] = 0;
          taken = 0;
        end
        default: ;
      endcase
      owed.push_back(r);
    endfunction

    // Compare one delivered result beat with the oldest owed lookup.
    function void check_result(lookup_t got);
      lookup_t exp_r;
      if (owed.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result beat %h", got);
        return;
      end
      exp_r = owed.pop_front();
      if (got !== exp_r) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: ok %b/%b page %h/%h frame %h/%h word %h/%h (exp/act)",
                   exp_r.ok, got.ok, exp_r.page, got.page, exp_r.frame, got.frame,
                   exp_r.word, got.word);
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  tlpt_in_if  in_ch ();
  tlpt_out_if out_ch ();
  page_table_scoreboard sb;
  int unsigned results_seen;
  int unsigned epoch_slots [6];

  two_level_page_table_engine dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  always begin
    clk_i = 1'b1;
    #2;
    clk_i = 1'b0;
    #2;
  end

  // Mostly short idle stretches, now and then a long one.
  function automatic int unsigned idle_len();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Offer one command beat and hold it until the engine takes it.
  task automatic send_cmd(logic [2:0] cmd, logic [PAGE_W-1:0] page,
                          logic [FRAME_W-1:0] frame, logic wr);
    int unsigned gap;
    gap = idle_len();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.command <= cmd;
    in_ch.page_number <= page;
    in_ch.frame_number <= frame;
    in_ch.writable <= wr;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    sb.note_command(cmd, page, frame, wr);
  endtask

  task automatic pick_slots();
    foreach (epoch_slots[i]) begin
      case ($urandom_range(0, 3))
        0: epoch_slots[i] = 0;
        1: epoch_slots[i] = DIR_ENTRIES - 1;
        default: epoch_slots[i] = $urandom_range(0, DIR_ENTRIES - 1);
      endcase
    end
  endtask

  // Pages cluster at the table ends so scans stay short.
  function automatic logic [PAGE_W-1:0] rand_page();
    int unsigned d;
    int unsigned t;
    d = ($urandom_range(0, 19) == 0) ? $urandom_range(DIR_ENTRIES, 1023)
                                     : epoch_slots[$urandom_range(0, 5)];
    case ($urandom_range(0, 7))
      0: t = $urandom_range(0, TABLE_ENTRIES - 1);
      1, 2: t = $urandom_range(TABLE_ENTRIES - 8, TABLE_ENTRIES - 1);
      default: t = $urandom_range(0, 7);
    endcase
    return PAGE_W'(d * TABLE_ENTRIES + t);
  endfunction

  // Result side: random ready, one long hold-off after forty results.
  initial begin
    int unsigned hold;
    bit          held;
    hold = 0;
    held = 0;
    results_seen = 0;
    out_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (out_ch.valid && out_ch.ready) begin
        sb.check_result({out_ch.ok, out_ch.found_page, out_ch.found_frame,
                         out_ch.entry_word});
        results_seen++;
      end
      if (!held && results_seen == 40) begin
        held = 1;
        hold = 300;
      end else if (hold == 0) begin
        hold = idle_len();
      end
      if (hold > 0) begin
        hold--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Stimulus: directed corners, then random command streams.
  initial begin
    int unsigned p;
    logic [2:0]  cmd;
    sb = new();
    rst_ni = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.command = CMD_GET;
    in_ch.page_number = '0;
    in_ch.frame_number = '0;
    in_ch.writable = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_cmd(CMD_FIRST, '0, '0, 1'b0);
    send_cmd(CMD_GET, 20'd5, '0, 1'b0);
    send_cmd(CMD_SET, '0, 20'hFFFFF, 1'b1);
    send_cmd(CMD_SET, 20'(DIR_ENTRIES*TABLE_ENTRIES - 1), '0, 1'b0);
    for (int i = 1; i < TABLE_POOL - 1; i++)
      send_cmd(CMD_SET, 20'(i*40*TABLE_ENTRIES + i), 20'($urandom), 1'($urandom));
    // Pool is used up now: a new slot must fail, a mapped slot still works.
    send_cmd(CMD_SET, 20'(700*TABLE_ENTRIES), 20'h12345, 1'b1);
    send_cmd(CMD_SET, 20'd1023, 20'hABCDE, 1'b0);
    send_cmd(CMD_SET, 20'hFFFFF, 20'h1, 1'b1);
    send_cmd(CMD_GET, 20'd1023, '0, 1'b0);
    send_cmd(CMD_CLEAR, '0, '0, 1'b0);
    send_cmd(CMD_GET, '0, '0, 1'b0);
    send_cmd(CMD_FIRST, '0, '0, 1'b0);
    send_cmd(CMD_NEXT, 20'd1023, '0, 1'b0);
    send_cmd(CMD_NEXT, 20'(DIR_ENTRIES*TABLE_ENTRIES - 1), '0, 1'b0);
    send_cmd(CMD_NEXT, 20'hFFFFF, '0, 1'b0);
    send_cmd(3'd6, 20'd1023, '0, 1'b0);
    send_cmd(3'd7, 20'd1023, '0, 1'b0);
    send_cmd(CMD_DESTROY, '0, '0, 1'b0);
    send_cmd(CMD_FIRST, '0, '0, 1'b0);

    pick_slots();
    for (int n = 0; n < 450; n++) begin
      p = $urandom_range(0, 99);
      if (p < 36) cmd = CMD_SET;
      else if (p < 56) cmd = CMD_GET;
      else if (p < 66) cmd = CMD_CLEAR;
      else if (p < 74) cmd = CMD_FIRST;
      else if (p < 92) cmd = CMD_NEXT;
      else if (p < 95) cmd = CMD_DESTROY;
      else cmd = 3'($urandom_range(6, 7));
      if (cmd == CMD_NEXT && $urandom_range(0, 3) != 0)
        send_cmd(cmd, sb.last_found, 20'($urandom), 1'($urandom));
      else
        send_cmd(cmd, rand_page(), 20'($urandom), 1'($urandom));
      if (cmd == CMD_DESTROY) pick_slots();
    end
    in_ch.valid <= 1'b0;

    while (sb.owed.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("[two_level_page_table_engine] OK");
    end else begin
      $display("[two_level_page_table_engine] ERROR");
    end
    $finish;
  end

  initial begin
    #500ms;
    $display("[two_level_page_table_engine] ERROR");
    $finish;
  end

endmodule

// ===== two_level_page_table_engine.f =====
sv/tlpt_pkg.sv
sv/tlpt_if.sv
sv/tlpt_ctrl.sv
sv/tlpt_datapath.sv
sv/two_level_page_table_engine.sv
tb/tb_two_level_page_table_engine.sv
